FILE: design/tdssm_pkg.sv
// ----------------------------------------------------------------------------
// tdssm_pkg: shared types and helpers for the two-digit display multiplexer
// Item layout between the input stage and the phase core, the digit split
// of a loaded value and the seven-segment decode table.
// ----------------------------------------------------------------------------
package tdssm_pkg;

    localparam int VALUE_W  = 16;
    localparam int STAMP_W  = 32;
    localparam int DUR_W    = 32;
    localparam int DIGIT_W  = 4;
    localparam int SEG_W    = 8;
    localparam int PHASE_W  = 2;
    localparam int CFG_IDX_W = 4;

    // Reciprocals for the constant divides, exact over all 16-bit values
    localparam logic [31:0] RECIP_10 = 32'd52429;   // x/10  = (x*RECIP_10) >> 19
    localparam logic [31:0] RECIP_25 = 32'd5243;    // x/100 = ((x>>2)*RECIP_25) >> 17

    typedef struct packed {
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] units;
    } digit_pair_t;

    // One refresh request after the input register
    typedef struct packed {
        logic               kind;
        digit_pair_t        digits;
        logic [STAMP_W-1:0] now_us;
    } item_t;

    // Split a value into its two lowest decimal digits
    function automatic digit_pair_t split_digits(input logic [VALUE_W-1:0] value);
        logic [31:0]        prod10;
        logic [31:0]        prod100;
        logic [12:0]        quot10;
        logic [9:0]         quot100;
        logic [12:0]        hund_x10;
        logic [VALUE_W-1:0] tens_x10;
        logic [12:0]        tens_full;
        logic [VALUE_W-1:0] units_full;
        digit_pair_t        res;
        prod10     = 32'(value) * RECIP_10;
        prod100    = 32'(value[VALUE_W-1:2]) * RECIP_25;
        quot10     = prod10[31:19];
        quot100    = prod100[26:17];
        hund_x10   = {quot100, 3'b000} + {2'b00, quot100, 1'b0};
        tens_x10   = {quot10[12:0], 3'b000} + {2'b00, quot10[12:0], 1'b0};
        tens_full  = quot10 - hund_x10;
        units_full = value - tens_x10;
        res.tens   = tens_full[DIGIT_W-1:0];
        res.units  = units_full[DIGIT_W-1:0];
        return res;
    endfunction

    // Standard a..g encoding, decimal point off
    function automatic logic [SEG_W-1:0] decode_digit(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] mask;
        case (digit)
            4'd0:    mask = 8'h3F;
            4'd1:    mask = 8'h06;
            4'd2:    mask = 8'h5B;
            4'd3:    mask = 8'h4F;
            4'd4:    mask = 8'h66;
            4'd5:    mask = 8'h6D;
            4'd6:    mask = 8'h7D;
            4'd7:    mask = 8'h07;
            4'd8:    mask = 8'h7F;
            4'd9:    mask = 8'h6F;
            default: mask = 8'h00;
        endcase
        return mask;
    endfunction

endpackage

FILE: design/tdssm_in_stage.sv
// ----------------------------------------------------------------------------
// tdssm_in_stage: input register of the display multiplexer
// Captures one refresh request, splits its value into decimal digits on the
// way in, and holds it until the phase core takes it.
// ----------------------------------------------------------------------------
module tdssm_in_stage
    import tdssm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [47:0]        s_tdata,   // [15:0] new_value, [47:16] now_us
    input  logic               s_tuser,   // [0] kind
    output logic               item_valid,
    output item_t              item,
    input  logic               item_take
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  s_accept;

    // Free a slot when empty or when the core drains the held request
    assign s_tready = !valid_reg || item_take;
    assign s_accept = s_tvalid && s_tready;

    // Track occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (s_accept)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load payload, digits split ahead of the core
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_reg.kind   <= s_tuser;
            item_reg.digits <= split_digits(s_tdata[15:0]);
            item_reg.now_us <= s_tdata[47:16];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: design/tdssm_phase_core.sv
// ----------------------------------------------------------------------------
// tdssm_phase_core: phase sequencer and pin state of the display multiplexer
// Holds the phase durations, the blank/tens/gap/units phase, the last change
// time and the pin levels, which double as the result register.
// ----------------------------------------------------------------------------
module tdssm_phase_core
    import tdssm_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]     cfg_data,
    input  logic                 item_valid,
    input  item_t                item,
    output logic                 item_take,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata
);

    localparam int CMP_W = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;

    localparam logic [PHASE_W-1:0] PH_BLANK = 2'd0;
    localparam logic [PHASE_W-1:0] PH_TENS  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_GAP   = 2'd2;
    localparam logic [PHASE_W-1:0] PH_UNITS = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BLANK = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TENS  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNITS = 4'd3;

    logic [DUR_W-1:0]     blank_time_reg;
    logic [DUR_W-1:0]     tens_time_reg;
    logic [DUR_W-1:0]     gap_time_reg;
    logic [DUR_W-1:0]     units_time_reg;

    logic [PHASE_W-1:0]   phase_reg,    phase_next;
    logic [TIME_BITS-1:0] last_reg,     last_next;
    digit_pair_t          digits_reg,   digits_next;
    logic [SEG_W-1:0]     segments_reg, segments_next;
    logic                 tens_reg,     tens_next;
    logic                 units_reg,    units_next;
    logic                 out_valid_reg, out_valid_next;

    logic [TIME_BITS-1:0] now_masked;
    logic [TIME_BITS-1:0] elapsed;
    logic [DUR_W-1:0]     duration;
    logic                 expired;

    // Configuration is always accepted; indexes past the list drop
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blank_time_reg <= '0;
            tens_time_reg  <= '0;
            gap_time_reg   <= '0;
            units_time_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BLANK: blank_time_reg <= cfg_data;
                REG_TENS:  tens_time_reg  <= cfg_data;
                REG_GAP:   gap_time_reg   <= cfg_data;
                REG_UNITS: units_time_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Advance whenever the result slot is free or being drained
    assign item_take = item_valid && (!out_valid_reg || m_tready);

    // Pick the running phase's duration
    always_comb
    begin
        case (phase_reg)
            PH_BLANK: duration = blank_time_reg;
            PH_TENS:  duration = tens_time_reg;
            PH_GAP:   duration = gap_time_reg;
            PH_UNITS: duration = units_time_reg;
            default:  duration = blank_time_reg;
        endcase
    end

    // Wrapping elapsed time since the last phase change
    assign now_masked = TIME_BITS'(item.now_us);
    assign elapsed    = now_masked - last_reg;
    assign expired    = CMP_W'(elapsed) >= CMP_W'(duration);

    // Step the phase and the pin levels
    always_comb
    begin
        phase_next    = phase_reg;
        last_next     = last_reg;
        digits_next   = item.kind ? item.digits : digits_reg;
        segments_next = segments_reg;
        tens_next     = tens_reg;
        units_next    = units_reg;
        if (expired)
        begin
            last_next  = now_masked;
            phase_next = phase_reg + 2'd1;
        end
        case (phase_reg)
            PH_TENS:
            begin
                if (expired)
                begin
                    segments_next = '0;
                    tens_next     = 1'b1;
                end
                else
                begin
                    segments_next = decode_digit(digits_next.tens);
                    tens_next     = 1'b0;
                end
            end
            PH_UNITS:
            begin
                if (expired)
                begin
                    segments_next = '0;
                    units_next    = 1'b1;
                end
                else
                begin
                    segments_next = decode_digit(digits_next.units);
                    units_next    = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (item_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BLANK;
            last_reg      <= '0;
            digits_reg    <= '0;
            segments_reg  <= '0;
            tens_reg      <= 1'b1;
            units_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (item_take)
            begin
                phase_reg    <= phase_next;
                last_reg     <= last_next;
                digits_reg   <= digits_next;
                segments_reg <= segments_next;
                tens_reg     <= tens_next;
                units_reg    <= units_next;
            end
        end
    end

    // Pin state after the last step is the result
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, phase_reg, units_reg, tens_reg, segments_reg};

    // Only the tens phase may sink the tens cathode
    a_tens_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !tens_reg |-> (phase_reg == PH_TENS))
        else $error("tens cathode low outside tens phase");

    // Only the units phase may sink the units cathode
    a_units_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !units_reg |-> (phase_reg == PH_UNITS))
        else $error("units cathode low outside units phase");

    // Lit segments need exactly one digit selected
    a_seg_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (segments_reg != '0) |-> (tens_reg != units_reg))
        else $error("segments lit without a single digit selected");

    // Phase moves by at most one step per request
    a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |=> (phase_reg == $past(phase_reg)) ||
                      (phase_reg == $past(phase_reg) + 2'd1))
        else $error("phase skipped a step");

    // No request, no phase change
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !item_take |=> $stable(phase_reg))
        else $error("phase changed without a request");

endmodule

FILE: design/two_digit_seven_segment_multiplexer.sv
// ----------------------------------------------------------------------------
// two_digit_seven_segment_multiplexer: two-digit multiplexed display driver
// Steps a blank / tens / gap / units cycle from timestamped refresh requests.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one refresh request per beat. s_tuser set loads
//   new_value (shown modulo 100) before the refresh; now_us is a free-running
//   microsecond stamp. Master channel m_*: one result per request with the
//   segment levels, both cathode levels and the phase after that refresh.
//   Config channel cfg_*: index 0..3 selects blank, tens, gap and units
//   durations in microseconds; other indexes are dropped. Write only while
//   idle; cfg_ready is always high.
//   Path: an accepted request lands in the input register, its result is
//   then loaded into the phase/pin register and can be taken from there.
//   Throughput is one request per cycle while m_tready is high, set by the
//   single phase update register loop.
//   Reset: blank phase, all durations zero, value 0, segments dark, both
//   cathodes high, no result pending. No clearing pass.
//   Stall: a held result keeps m_tdata steady; one more request waits in the
//   input register, after which s_tready drops until m_tready returns.
// ----------------------------------------------------------------------------
module two_digit_seven_segment_multiplexer
    import tdssm_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,    // [15:0] new_value, [47:16] now_us
    input  logic                 s_tuser,    // [0] kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,    // [7:0] segments, [8] tens_cathode,
                                             // [9] units_cathode, [11:10] phase
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]     cfg_data
);

    logic  item_valid;
    item_t item;
    logic  item_take;

    // Input register with digit split
    tdssm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // Phase sequencer and result register
    tdssm_phase_core #(
        .TIME_BITS (TIME_BITS)
    ) u_phase_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
